// File: design/tgard_pkg.sv
package tgard_pkg;

    localparam int COUNT_BITS = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] CFG_BYTES_PER_PIXEL  = 2'd0;
    localparam logic [1:0] CFG_RUN_LENGTH_CODED = 2'd1;
    localparam logic [1:0] CFG_EXPAND_TO_FOUR   = 2'd2;
    localparam logic [1:0] CFG_PIXEL_TOTAL      = 2'd3;

    localparam logic [7:0] RUN_FLAG    = 8'h80;
    localparam logic [7:0] COUNT_FIELD = 8'h7f;
    localparam logic [7:0] OPAQUE      = 8'hff;

    typedef struct packed {
        logic [23:0] assembly;
        logic [7:0]  final_byte;
        logic [1:0]  top;
        logic        add_alpha;
        logic [7:0]  repeat_count;
        logic        last_of_image;
        logic        status;
    } pixel_entry_t;

endpackage

// File: design/tgard_front.sv
module tgard_front import tgard_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 first_byte,
    output logic                 push,
    output pixel_entry_t         push_entry
);

    logic [2:0]            bytes_per_pixel_reg;
    logic                  run_length_coded_reg;
    logic                  expand_to_four_reg;
    logic [31:0]           pixel_total_reg;

    logic                  expect_header_reg, expect_header_next;
    logic                  packet_is_run_reg, packet_is_run_next;
    logic [7:0]            packet_left_reg, packet_left_next;
    logic [1:0]            byte_in_pixel_reg, byte_in_pixel_next;
    logic [23:0]           assembly_reg, assembly_next;
    logic [COUNT_BITS-1:0] remaining_reg, remaining_next;

    logic                  supported;
    logic                  hdr_eff;
    logic                  run_eff;
    logic [7:0]            left_eff;
    logic [1:0]            bip_eff;
    logic [23:0]           asm_eff;
    logic [COUNT_BITS-1:0] rem_eff;
    logic [1:0]            top;
    logic [2:0]            bpp_minus_one;
    logic [7:0]            rep_raw;
    logic [7:0]            rep_clip;
    logic [7:0]            left_after;
    logic [COUNT_BITS-1:0] rem_after;
    logic [23:0]           shifted_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_per_pixel_reg  <= 3'd4;
            run_length_coded_reg <= 1'b0;
            expand_to_four_reg   <= 1'b0;
            pixel_total_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BYTES_PER_PIXEL:  bytes_per_pixel_reg  <= cfg_data[2:0];
                CFG_RUN_LENGTH_CODED: run_length_coded_reg <= cfg_data[0];
                CFG_EXPAND_TO_FOUR:   expand_to_four_reg   <= cfg_data[0];
                CFG_PIXEL_TOTAL:      pixel_total_reg      <= cfg_data;
                default:              pixel_total_reg      <= pixel_total_reg;
            endcase
        end
    end

    assign supported = (bytes_per_pixel_reg == 3'd1) || (bytes_per_pixel_reg == 3'd3)
                    || (bytes_per_pixel_reg == 3'd4);
    assign bpp_minus_one = bytes_per_pixel_reg - 3'd1;
    assign top = bpp_minus_one[1:0];

    assign hdr_eff  = first_byte ? 1'b1  : expect_header_reg;
    assign run_eff  = first_byte ? 1'b0  : packet_is_run_reg;
    assign left_eff = first_byte ? 8'd0  : packet_left_reg;
    assign bip_eff  = first_byte ? 2'd0  : byte_in_pixel_reg;
    assign asm_eff  = first_byte ? 24'd0 : assembly_reg;
    assign rem_eff  = first_byte ? pixel_total_reg[COUNT_BITS-1:0] : remaining_reg;

    assign rep_raw    = (run_length_coded_reg && run_eff) ? left_eff : 8'd1;
    assign left_after = run_eff ? 8'd0 : left_eff - 8'd1;
    assign rep_clip   = (rem_eff < COUNT_BITS'(rep_raw)) ? rem_eff[7:0] : rep_raw;
    assign rem_after  = rem_eff - COUNT_BITS'(rep_clip);

    always_comb
    begin
        shifted_byte = '0;
        case (bip_eff)
            2'd0:    shifted_byte = {16'd0, data_byte};
            2'd1:    shifted_byte = {8'd0, data_byte, 8'd0};
            default: shifted_byte = {data_byte, 16'd0};
        endcase
    end

    always_comb
    begin
        expect_header_next = hdr_eff;
        packet_is_run_next = run_eff;
        packet_left_next   = left_eff;
        byte_in_pixel_next = bip_eff;
        assembly_next      = asm_eff;
        remaining_next     = rem_eff;
        push               = 1'b0;
        push_entry         = '0;

        if (!supported)
        begin
            if (first_byte)
            begin
                remaining_next           = '0;
                push                     = 1'b1;
                push_entry.repeat_count  = 8'd1;
                push_entry.last_of_image = 1'b1;
                push_entry.status        = 1'b1;
            end
        end
        else if (rem_eff != '0)
        begin
            if (run_length_coded_reg && hdr_eff)
            begin
                packet_is_run_next = (data_byte & RUN_FLAG) != 8'd0;
                packet_left_next   = (data_byte & COUNT_FIELD) + 8'd1;
                expect_header_next = 1'b0;
                byte_in_pixel_next = 2'd0;
                assembly_next      = '0;
            end
            else if (bip_eff < top)
            begin
                assembly_next      = asm_eff | shifted_byte;
                byte_in_pixel_next = bip_eff + 2'd1;
            end
            else
            begin
                byte_in_pixel_next       = 2'd0;
                assembly_next            = '0;
                if (run_length_coded_reg)
                begin
                    packet_left_next = left_after;
                    if (left_after == 8'd0)
                    begin
                        expect_header_next = 1'b1;
                    end
                end
                remaining_next           = rem_after;
                push                     = 1'b1;
                push_entry.assembly      = asm_eff;
                push_entry.final_byte    = data_byte;
                push_entry.top           = top;
                push_entry.add_alpha     = (bytes_per_pixel_reg == 3'd3) && expand_to_four_reg;
                push_entry.repeat_count  = rep_clip;
                push_entry.last_of_image = rem_after == '0;
                push_entry.status        = 1'b0;
            end
        end

        if (!accept)
        begin
            push = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_header_reg <= 1'b1;
            packet_is_run_reg <= 1'b0;
            packet_left_reg   <= '0;
            byte_in_pixel_reg <= '0;
            assembly_reg      <= '0;
            remaining_reg     <= '0;
        end
        else if (accept)
        begin
            expect_header_reg <= expect_header_next;
            packet_is_run_reg <= packet_is_run_next;
            packet_left_reg   <= packet_left_next;
            byte_in_pixel_reg <= byte_in_pixel_next;
            assembly_reg      <= assembly_next;
            remaining_reg     <= remaining_next;
        end
    end

endmodule

// File: design/tgard_queue.sv
module tgard_queue import tgard_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  pixel_entry_t push_entry,
    input  logic         pop,
    output logic         full,
    output logic         not_empty,
    output pixel_entry_t head
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    pixel_entry_t          entries [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS:0]     count_reg;

    assign full      = count_reg == (PTR_BITS+1)'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_BITS+1)'(QUEUE_DEPTH))
        else $error("Request queue holds more entries than it has.");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("Request taken from an empty queue.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("Queue count did not follow a lone push.");

endmodule

// File: design/tgard_back.sv
module tgard_back import tgard_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         not_empty,
    input  pixel_entry_t head,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [31:0]  pixel_value,
    output logic [7:0]   repeat_count,
    output logic         last_of_image,
    output logic         status
);

    logic        out_valid_reg;
    logic [31:0] value_reg;
    logic [7:0]  repeat_reg;
    logic        last_reg;
    logic        status_reg;
    logic [31:0] value_next;

    assign pop = not_empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        value_next = '0;
        case (head.top)
            2'd0:    value_next = {24'd0, head.final_byte};
            2'd1:    value_next = {16'd0, head.final_byte, head.assembly[7:0]};
            2'd2:    value_next = {8'd0, head.final_byte, head.assembly[15:0]};
            default: value_next = {head.final_byte, head.assembly};
        endcase
        if (head.add_alpha)
        begin
            value_next[31:24] = OPAQUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            value_reg  <= value_next;
            repeat_reg <= head.repeat_count;
            last_reg   <= head.last_of_image;
            status_reg <= head.status;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_value   = value_reg;
    assign repeat_count  = repeat_reg;
    assign last_of_image = last_reg;
    assign status        = status_reg;

endmodule

// File: design/tga_rle_pixel_decoder_top.sv
// Decodes the pixel-data bytes of a TGA image into pixels with repeat counts.
// The input channel (in_valid, in_ready) carries one byte per request, with
// first_byte marking the first byte of a new image. The output channel
// (out_valid, out_ready) carries one pixel per request: its value, how many
// times it repeats, whether it ends the image and a status flag.
// The configuration channel (cfg_valid, cfg_ready) writes one register per
// request and is always ready; it should only be used while the block is idle.
// Throughput is one byte per cycle while in_ready is high, set by the parse and
// pixel counter loop in the front end. A byte that completes a pixel passes
// through the queue and the output register before it reaches the output.
// After reset the pixel counter is zero, so bytes are dropped until a request
// with first_byte set starts an image. If the receiver stalls, up to two
// pixels wait in the queue and one in the output register; in_ready then
// falls until the receiver takes a pixel again.
module tga_rle_pixel_decoder_top import tgard_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   data_byte,
    input  logic         first_byte,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [31:0]  pixel_value,
    output logic [7:0]   repeat_count,
    output logic         last_of_image,
    output logic         status
);

    logic         accept;
    logic         push;
    logic         pop;
    logic         full;
    logic         not_empty;
    pixel_entry_t push_entry;
    pixel_entry_t head;

    assign cfg_ready = 1'b1;
    assign in_ready  = !full;
    assign accept    = in_valid && !full;

    tgard_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .data_byte  (data_byte),
        .first_byte (first_byte),
        .push       (push),
        .push_entry (push_entry)
    );

    tgard_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .not_empty  (not_empty),
        .head       (head)
    );

    tgard_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .not_empty     (not_empty),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_value   (pixel_value),
        .repeat_count  (repeat_count),
        .last_of_image (last_of_image),
        .status        (status)
    );

endmodule

// File: sim/tb_top.sv
module tb_top import tgard_pkg::*; ();

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_BAD_SIZE = 1'b1;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 120;
    localparam int SETTLE_CYCLES = 6;
    localparam logic [31:0] TOTAL_MAX = 32'hFFFE_0001;

    typedef struct packed {
        logic [31:0] pix;
        logic [7:0]  reps;
        logic        last;
        logic        stat;
    } pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_BYTES_PER_PIXEL;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        first_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] pixel_value;
    logic [7:0]  repeat_count;
    logic        last_of_image;
    logic        status;

    // Register copies and parse state of the decoder as predicted here.
    logic [2:0]  reg_bpp = 3'd4;
    logic        reg_rle = 1'b0;
    logic        reg_alpha = 1'b0;
    logic [31:0] reg_total = '0;

    logic                  want_header = 1'b1;
    logic                  run_packet = 1'b0;
    logic [7:0]            packet_left = '0;
    logic [1:0]            byte_pos = '0;
    logic [23:0]           assembly = '0;
    logic [COUNT_BITS-1:0] remaining = '0;

    pixel_t pixels_due[$];
    int     mismatches = 0;
    int     bytes_decoded = 0;
    int     quiet_cycles = 0;

    logic steady_flow = 1'b0;
    logic stall_request = 1'b0;
    int   stall_left = 0;
    logic start_pending = 1'b0;

    tga_rle_pixel_decoder_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .first_byte(first_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .pixel_value(pixel_value),
        .repeat_count(repeat_count),
        .last_of_image(last_of_image),
        .status(status)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void apply_register(input logic [1:0] idx, input logic [31:0] d);
        case (idx)
            CFG_BYTES_PER_PIXEL:  reg_bpp = d[2:0];
            CFG_RUN_LENGTH_CODED: reg_rle = d[0];
            CFG_EXPAND_TO_FOUR:   reg_alpha = d[0];
            CFG_PIXEL_TOTAL:      reg_total = d;
            default:              ;
        endcase
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic start);
        pixel_t      p;
        logic        supported;
        int          top;
        logic [31:0] value;
        logic [31:0] rep;
        supported = (reg_bpp == 3'd1) || (reg_bpp == 3'd3) || (reg_bpp == 3'd4);
        bytes_decoded++;
        if (start)
        begin
            want_header = 1'b1;
            run_packet = 1'b0;
            packet_left = '0;
            byte_pos = '0;
            assembly = '0;
            if (!supported)
            begin
                remaining = '0;
                p.pix = '0;
                p.reps = 8'd1;
                p.last = 1'b1;
                p.stat = STATUS_BAD_SIZE;
                pixels_due.push_back(p);
                return;
            end
            remaining = reg_total[COUNT_BITS-1:0];
        end
        if (!supported || remaining == 0)
            return;
        if (reg_rle && want_header)
        begin
            run_packet = (b & RUN_FLAG) != 8'd0;
            packet_left = (b & COUNT_FIELD) + 8'd1;
            want_header = 1'b0;
            byte_pos = '0;
            assembly = '0;
            return;
        end
        top = int'(reg_bpp) - 1;
        if (int'(byte_pos) < top)
        begin
            assembly = assembly | (24'(b) << (8 * byte_pos));
            byte_pos = byte_pos + 2'd1;
            return;
        end
        value = (32'(assembly) & (32'h00FF_FFFF >> (8 * (3 - top)))) | (32'(b) << (8 * top));
        if (reg_bpp == 3'd3 && reg_alpha)
            value[31:24] = OPAQUE;
        byte_pos = '0;
        assembly = '0;
        rep = 32'd1;
        if (reg_rle)
        begin
            if (run_packet)
            begin
                rep = 32'(packet_left);
                packet_left = '0;
            end
            else
                packet_left = packet_left - 8'd1;
            if (packet_left == 8'd0)
                want_header = 1'b1;
        end
        if (rep > 32'(remaining))
            rep = 32'(remaining);
        remaining = remaining - rep[COUNT_BITS-1:0];
        p.pix = value;
        p.reps = rep[7:0];
        p.last = (remaining == 0);
        p.stat = STATUS_OK;
        pixels_due.push_back(p);
    endfunction

    task automatic check_pixel();
        pixel_t want;
        if (pixels_due.size() == 0)
        begin
            $error("unexpected pixel: pixel_value %h repeat_count %0d", pixel_value, repeat_count);
            mismatches++;
        end
        else
        begin
            want = pixels_due.pop_front();
            if (pixel_value !== want.pix)
            begin
                $error("pixel_value: expected %h, got %h", want.pix, pixel_value);
                mismatches++;
            end
            if (repeat_count !== want.reps)
            begin
                $error("repeat_count: expected %0d, got %0d", want.reps, repeat_count);
                mismatches++;
            end
            if (last_of_image !== want.last)
            begin
                $error("last_of_image: expected %b, got %b", want.last, last_of_image);
                mismatches++;
            end
            if (status !== want.stat)
            begin
                $error("status: expected %b, got %b", want.stat, status);
                mismatches++;
            end
        end
    endtask

    // Every accepted request is seen here: register writes and bytes update the
    // prediction before any pixel of the same edge is checked.
    always @(posedge clk)
    begin
        if (cfg_valid && cfg_ready)
            apply_register(cfg_index, cfg_data);
        if (in_valid && in_ready)
            decode_byte(data_byte, first_byte);
        if (out_valid && out_ready)
            check_pixel();
    end

    always @(posedge clk)
    begin
        if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** tga_rle_pixel_decoder_top: FAILED **");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (stall_request)
        begin
            stall_left = HOLD_CYCLES;
            stall_request = 1'b0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (steady_flow)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 36);
    end

    task automatic send_byte(input logic [7:0] b, input logic start);
        int gap;
        gap = 0;
        while (!steady_flow && $urandom_range(99) < 36)
            gap++;
        @(negedge clk);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        first_byte <= start;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure_decoder(input logic [2:0] bpp, input logic rle,
                                     input logic alpha, input logic [31:0] total);
        wait_drained();
        write_register(CFG_BYTES_PER_PIXEL, 32'(bpp));
        write_register(CFG_RUN_LENGTH_CODED, 32'(rle));
        write_register(CFG_EXPAND_TO_FOUR, 32'(alpha));
        write_register(CFG_PIXEL_TOTAL, total);
    endtask

    // The first byte of an image usually carries first_byte; now and then a stray
    // restart is thrown into the middle of a stream.
    task automatic stream_byte(input logic [7:0] b);
        logic start;
        start = start_pending ? 1'b1 : ($urandom_range(49) == 0);
        start_pending = 1'b0;
        send_byte(b, start);
    endtask

    task automatic stream_pixel(input int bpp);
        for (int i = 0; i < bpp; i++)
            stream_byte(8'($urandom_range(255)));
    endtask

    task automatic decode_random_image();
        int          bpp;
        int          pick;
        logic        rle;
        logic [31:0] total;
        int          goal;
        int          produced;
        int          count;
        logic        run;
        pick = $urandom_range(99);
        if (pick < 8)
            bpp = 2;
        else if (pick < 38)
            bpp = 1;
        else if (pick < 69)
            bpp = 3;
        else
            bpp = 4;
        rle = 1'($urandom_range(1));
        pick = $urandom_range(19);
        if (pick == 0)
            total = '0;
        else if (pick == 1)
            total = TOTAL_MAX;
        else if (pick == 2)
            total = $urandom_range(TOTAL_MAX, 100);
        else
            total = $urandom_range(40, 1);
        configure_decoder(3'(bpp), rle, 1'($urandom_range(1)), total);
        start_pending = ($urandom_range(9) != 0);
        goal = (bpp == 2) ? 2 : ((total < 48) ? int'(total) : 48);
        produced = 0;
        while (produced < goal || start_pending)
        begin
            if (rle)
            begin
                count = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(5);
                run = 1'($urandom_range(1));
                stream_byte({run, 7'(count)});
                if (run)
                    stream_pixel(bpp);
                else
                    repeat (count + 1) stream_pixel(bpp);
                produced += count + 1;
            end
            else
            begin
                stream_pixel(bpp);
                produced++;
            end
        end
        repeat ($urandom_range(3)) send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic run_random_images(input int budget);
        int mark;
        mark = bytes_decoded;
        while (bytes_decoded - mark < budget)
            decode_random_image();
    endtask

    // No image has been started yet, so these bytes must be dropped.
    task automatic test_idle_after_reset();
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b0);
    endtask

    task automatic test_raw_pixels();
        configure_decoder(3'd4, 1'b0, 1'b0, 32'd3);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        configure_decoder(3'd1, 1'b0, 1'b0, 32'd2);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        configure_decoder(3'd3, 1'b0, 1'b1, 32'd1);
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(8'h56, 1'b0);
    endtask

    task automatic test_run_packets();
        configure_decoder(3'd1, 1'b1, 1'b0, 32'd200);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // A run of six against three pixels left is clipped, and the byte
        // after the end of the image gives nothing.
        configure_decoder(3'd3, 1'b1, 1'b0, 32'd3);
        send_byte(8'h85, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'hAB, 1'b0);
    endtask

    task automatic test_unsupported_size();
        configure_decoder(3'd2, 1'b0, 1'b0, 32'd5);
        send_byte(8'h00, 1'b1);
        send_byte(8'h11, 1'b0);
    endtask

    task automatic test_size_change();
        configure_decoder(3'd4, 1'b0, 1'b0, 32'd8);
        send_byte(8'h01, 1'b1);
        send_byte(8'h02, 1'b0);
        wait_drained();
        write_register(CFG_BYTES_PER_PIXEL, 32'd3);
        send_byte(8'h03, 1'b0);
    endtask

    task automatic test_pixel_total_extremes();
        configure_decoder(3'd1, 1'b0, 1'b0, 32'd0);
        send_byte(8'h42, 1'b1);
        configure_decoder(3'd1, 1'b0, 1'b0, TOTAL_MAX);
        send_byte(8'h24, 1'b1);
    endtask

    task automatic test_output_stall();
        configure_decoder(3'd1, 1'b0, 1'b0, 32'd1000);
        stall_request = 1'b1;
        send_byte(8'($urandom_range(255)), 1'b1);
        repeat (39) send_byte(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic test_streaming_no_gaps();
        steady_flow = 1'b1;
        run_random_images(150);
        steady_flow = 1'b0;
    endtask

    task automatic test_random_images();
        run_random_images(1130);
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        test_idle_after_reset();
        test_raw_pixels();
        test_run_packets();
        test_unsupported_size();
        test_size_change();
        test_pixel_total_extremes();
        test_output_stall();
        test_streaming_no_gaps();
        test_random_images();
        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pixels_due.size() == 0)
            $display("** tga_rle_pixel_decoder_top: PASSED **");
        else
            $display("** tga_rle_pixel_decoder_top: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
design/tgard_pkg.sv
design/tgard_front.sv
design/tgard_queue.sv
design/tgard_back.sv
design/tga_rle_pixel_decoder_top.sv
sim/tb_top.sv
